FILE: sv/kcst_pkg.sv
// ---------------------------------------------------------------------------
// kcst_pkg
// Shared types and constants for the keyed count slot table.
// ---------------------------------------------------------------------------
package kcst_pkg;

    localparam int SLOTS_DEFAULT = 16;

    localparam int KEY_W   = 8;
    localparam int COUNT_W = 16;
    localparam int MODE_W  = 2;

    // beat layouts
    localparam int IN_TDATA_W  = 24;   // item_key, amount
    localparam int IN_TUSER_W  = MODE_W;
    localparam int OUT_TDATA_W = 8;    // ok, saturated, zero pad

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    typedef enum logic [MODE_W-1:0] {
        MODE_ADD    = 2'd0,
        MODE_REMOVE = 2'd1,
        MODE_QUERY  = 2'd2
    } mode_t;

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_SCAN   = 4'b0010,
        ST_UPDATE = 4'b0100,
        ST_DONE   = 4'b1000
    } state_t;

endpackage

FILE: sv/keyed_count_slot_table_top.sv
// ---------------------------------------------------------------------------
// keyed_count_slot_table_top
// Slot table of (key, count) pairs with add, remove and query operations.
// ---------------------------------------------------------------------------
// One operation per input beat, one result beat per operation. The block
// takes a beat only when idle; each operation then scans every slot once
// through the single-port slot memory (one read per cycle with registered
// read data), writes back the chosen slot in the update state and loads
// the result register in the done state before returning to idle. The
// result register lets the next beat be taken while the previous result
// still waits downstream. Slot valid bits sit in flip-flops and clear at
// reset, so the memory needs no clearing pass; a free slot never matches,
// whatever key it still holds. One 17-bit adder/subtractor serves both the
// count >= amount test during the scan and the count update afterwards.
// Add saturates at the count maximum and raises saturated; mode 3 is a
// no-op returning ok = 0.
// ---------------------------------------------------------------------------
module keyed_count_slot_table_top #(
    parameter int SLOTS = kcst_pkg::SLOTS_DEFAULT
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // [7:0] item_key, [23:8] amount
    input  logic [kcst_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
    // [1:0] mode
    input  logic [kcst_pkg::IN_TUSER_W-1:0]   s_axis_tuser,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // [0] ok, [1] saturated, [7:2] zero
    output logic [kcst_pkg::OUT_TDATA_W-1:0]  m_axis_tdata
);

    import kcst_pkg::*;

    localparam int IDX_W   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W   = $clog2(SLOTS + 1);
    localparam int ENTRY_W = KEY_W + COUNT_W;

    // control state
    state_t                 state_reg, state_next;
    logic [CNT_W-1:0]       rd_cnt_reg, rd_cnt_next;
    logic                   cmp_valid_reg, cmp_valid_next;
    logic [IDX_W-1:0]       cmp_idx_reg, cmp_idx_next;
    logic                   hit_found_reg, hit_found_next;
    logic                   free_found_reg, free_found_next;
    logic [SLOTS-1:0]       valid_reg, valid_next;
    logic                   out_valid_reg, out_valid_next;

    // payload
    mode_t                  mode_reg, mode_next;
    logic [KEY_W-1:0]       key_reg, key_next;
    logic [COUNT_W-1:0]     amount_reg, amount_next;
    logic [IDX_W-1:0]       hit_idx_reg, hit_idx_next;
    logic [COUNT_W-1:0]     hit_cnt_reg, hit_cnt_next;
    logic [IDX_W-1:0]       free_idx_reg, free_idx_next;
    logic                   res_ok_reg, res_ok_next;
    logic                   res_sat_reg, res_sat_next;
    logic                   out_ok_reg, out_ok_next;
    logic                   out_sat_reg, out_sat_next;

    // slot memory
    logic [ENTRY_W-1:0]     mem [SLOTS];
    logic [ENTRY_W-1:0]     rd_data_reg;
    logic                   rd_en;
    logic [IDX_W-1:0]       rd_addr;
    logic                   wr_en;
    logic [IDX_W-1:0]       wr_addr;
    logic [ENTRY_W-1:0]     wr_data;
    logic [KEY_W-1:0]       rd_key;
    logic [COUNT_W-1:0]     rd_count;

    // shared add/sub unit; bit COUNT_W is carry on add, borrow on subtract
    logic                   au_sub;
    logic [COUNT_W-1:0]     au_a;
    logic [COUNT_W-1:0]     au_b;
    logic [COUNT_W:0]       au_res;

    logic                   key_hit;

    assign rd_en   = (state_reg == ST_SCAN) && (rd_cnt_reg < CNT_W'(SLOTS));
    assign rd_addr = rd_cnt_reg[IDX_W-1:0];
    assign rd_key   = rd_data_reg[ENTRY_W-1:COUNT_W];
    assign rd_count = rd_data_reg[COUNT_W-1:0];

    assign au_sub = (state_reg == ST_SCAN) || (mode_reg == MODE_REMOVE);
    assign au_a   = (state_reg == ST_SCAN) ? rd_count : hit_cnt_reg;
    assign au_b   = amount_reg;
    assign au_res = au_sub ? ({1'b0, au_a} + {1'b1, ~au_b} + {{COUNT_W{1'b0}}, 1'b1})
                           : ({1'b0, au_a} + {1'b0, au_b});

    assign key_hit = valid_reg[cmp_idx_reg] && (rd_key == key_reg);

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        rd_cnt_next     = rd_cnt_reg;
        cmp_valid_next  = cmp_valid_reg;
        cmp_idx_next    = cmp_idx_reg;
        hit_found_next  = hit_found_reg;
        free_found_next = free_found_reg;
        valid_next      = valid_reg;
        out_valid_next  = out_valid_reg;
        mode_next       = mode_reg;
        key_next        = key_reg;
        amount_next     = amount_reg;
        hit_idx_next    = hit_idx_reg;
        hit_cnt_next    = hit_cnt_reg;
        free_idx_next   = free_idx_reg;
        res_ok_next     = res_ok_reg;
        res_sat_next    = res_sat_reg;
        out_ok_next     = out_ok_reg;
        out_sat_next    = out_sat_reg;
        wr_en           = 1'b0;
        wr_addr         = hit_idx_reg;
        wr_data         = {key_reg, au_res[COUNT_W-1:0]};

        if (out_valid_reg && m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    mode_next       = mode_t'(s_axis_tuser[MODE_W-1:0]);
                    key_next        = s_axis_tdata[KEY_W-1:0];
                    amount_next     = s_axis_tdata[KEY_W+COUNT_W-1:KEY_W];
                    rd_cnt_next     = '0;
                    cmp_valid_next  = 1'b0;
                    hit_found_next  = 1'b0;
                    free_found_next = 1'b0;
                    state_next      = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                cmp_valid_next = rd_en;
                cmp_idx_next   = rd_addr;
                if (rd_en)
                begin
                    rd_cnt_next = rd_cnt_reg + 1'b1;
                end
                if (cmp_valid_reg)
                begin
                    case (mode_reg)
                        MODE_ADD:
                        begin
                            if (!hit_found_reg && key_hit)
                            begin
                                hit_found_next = 1'b1;
                                hit_idx_next   = cmp_idx_reg;
                                hit_cnt_next   = rd_count;
                            end
                            if (!free_found_reg && !valid_reg[cmp_idx_reg])
                            begin
                                free_found_next = 1'b1;
                                free_idx_next   = cmp_idx_reg;
                            end
                        end
                        MODE_REMOVE, MODE_QUERY:
                        begin
                            // borrow clear means count >= amount
                            if (!hit_found_reg && key_hit && !au_res[COUNT_W])
                            begin
                                hit_found_next = 1'b1;
                                hit_idx_next   = cmp_idx_reg;
                                hit_cnt_next   = rd_count;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
                // last slot is compared in the cycle after its read
                if (!rd_en)
                begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                res_ok_next  = 1'b0;
                res_sat_next = 1'b0;
                case (mode_reg)
                    MODE_ADD:
                    begin
                        if (hit_found_reg)
                        begin
                            wr_en        = 1'b1;
                            wr_addr      = hit_idx_reg;
                            wr_data      = {key_reg,
                                            au_res[COUNT_W] ? COUNT_MAX
                                                            : au_res[COUNT_W-1:0]};
                            res_ok_next  = 1'b1;
                            res_sat_next = au_res[COUNT_W];
                        end
                        else if (free_found_reg)
                        begin
                            wr_en                     = 1'b1;
                            wr_addr                   = free_idx_reg;
                            wr_data                   = {key_reg, amount_reg};
                            valid_next[free_idx_reg]  = 1'b1;
                            res_ok_next               = 1'b1;
                        end
                    end
                    MODE_REMOVE:
                    begin
                        if (hit_found_reg)
                        begin
                            wr_en       = 1'b1;
                            wr_addr     = hit_idx_reg;
                            wr_data     = {key_reg, au_res[COUNT_W-1:0]};
                            res_ok_next = 1'b1;
                            if (au_res[COUNT_W-1:0] == '0)
                            begin
                                valid_next[hit_idx_reg] = 1'b0;
                            end
                        end
                    end
                    MODE_QUERY:
                    begin
                        res_ok_next = hit_found_reg;
                    end
                    default:
                    begin
                    end
                endcase
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_valid_next = 1'b1;
                    out_ok_next    = res_ok_reg;
                    out_sat_next   = res_sat_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            rd_cnt_reg     <= '0;
            cmp_valid_reg  <= 1'b0;
            hit_found_reg  <= 1'b0;
            free_found_reg <= 1'b0;
            valid_reg      <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            rd_cnt_reg     <= rd_cnt_next;
            cmp_valid_reg  <= cmp_valid_next;
            hit_found_reg  <= hit_found_next;
            free_found_reg <= free_found_next;
            valid_reg      <= valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmp_idx_reg  <= cmp_idx_next;
        mode_reg     <= mode_next;
        key_reg      <= key_next;
        amount_reg   <= amount_next;
        hit_idx_reg  <= hit_idx_next;
        hit_cnt_reg  <= hit_cnt_next;
        free_idx_reg <= free_idx_next;
        res_ok_reg   <= res_ok_next;
        res_sat_reg  <= res_sat_next;
        out_ok_reg   <= out_ok_next;
        out_sat_reg  <= out_sat_next;
    end

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(OUT_TDATA_W-2){1'b0}}, out_sat_reg, out_ok_reg};

`ifndef SYNTH
    // an accepted beat always starts a scan
    a_accept_scan: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> (state_reg == ST_SCAN))
        else $error("accepted beat did not start a scan");

    // a new result only appears out of the done state
    a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_next && !out_valid_reg) |-> (state_reg == ST_DONE))
        else $error("result loaded outside done state");

    // saturation is only reported on a successful add
    a_sat_implies_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tdata[1]) |-> m_axis_tdata[0])
        else $error("saturated without ok");
`endif

endmodule
